// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Check that cons holds in the cycle after ante
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: sv/y86ex_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// y86ex_pkg
// Instruction, function, condition and status codes for the execute stage.
// ----------------------------------------------------------------------------
package y86ex_pkg;

    // Machine word size in bytes, used by stack pointer updates
    localparam int unsigned WORD_BYTES = 4;

    typedef logic [1:0]  stat_t;
    typedef logic [3:0]  code_t;
    typedef logic [31:0] word_t;

    // Condition flags
    typedef struct packed {
        logic zf;
        logic sf;
        logic of;
    } flags_t;

    // Status codes
    localparam stat_t STAT_AOK = 2'd0;
    localparam stat_t STAT_ADR = 2'd1;
    localparam stat_t STAT_INS = 2'd2;
    localparam stat_t STAT_HLT = 2'd3;

    // Instruction codes
    localparam code_t I_HALT   = 4'd0;
    localparam code_t I_NOP    = 4'd1;
    localparam code_t I_RRMOVL = 4'd2;
    localparam code_t I_IRMOVL = 4'd3;
    localparam code_t I_RMMOVL = 4'd4;
    localparam code_t I_MRMOVL = 4'd5;
    localparam code_t I_OPL    = 4'd6;
    localparam code_t I_JXX    = 4'd7;
    localparam code_t I_CALL   = 4'd8;
    localparam code_t I_RET    = 4'd9;
    localparam code_t I_PUSHL  = 4'd10;
    localparam code_t I_POPL   = 4'd11;
    localparam code_t I_DUMP   = 4'd12;

    // ALU functions
    localparam code_t ALU_ADD = 4'd0;
    localparam code_t ALU_SUB = 4'd1;
    localparam code_t ALU_AND = 4'd2;
    localparam code_t ALU_XOR = 4'd3;

    // Branch and move conditions
    localparam code_t C_ALWAYS = 4'd0;
    localparam code_t C_LE     = 4'd1;
    localparam code_t C_L      = 4'd2;
    localparam code_t C_E      = 4'd3;
    localparam code_t C_NE     = 4'd4;
    localparam code_t C_GE     = 4'd5;
    localparam code_t C_G      = 4'd6;

    // Register number meaning no destination
    localparam code_t REG_NONE = 4'd15;

endpackage

// File: sv/y86_execute_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// y86_execute_stage
// Y86 pipeline execute stage: ALU, condition flags, condition evaluation.
// ----------------------------------------------------------------------------
// Takes one instruction word per clock while not stalled and returns one result
// word per word taken. The word is captured in the input register when accepted
// and moves to the result register when that register is empty or being taken;
// the result register drives the outputs until the receiver takes the word.
// The ALU, the condition logic and the ZF/SF/OF flag register all sit between
// those two registers, so an instruction sees the flags left by the one just
// before it; that flag loop sets the rate of one word per clock.
// A stall on the result side holds the result register and, once the input
// register is also full, raises the input stall.

`include "assert_macros.svh"

module y86_execute_stage
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  y86ex_pkg::stat_t      status_in,
    input  y86ex_pkg::code_t      icode,
    input  y86ex_pkg::code_t      ifun,
    input  y86ex_pkg::word_t      val_c,
    input  y86ex_pkg::word_t      val_a,
    input  y86ex_pkg::word_t      val_b,
    input  y86ex_pkg::code_t      dest_e,
    input  y86ex_pkg::code_t      dest_m,
    input  y86ex_pkg::stat_t      mem_stage_stat,
    input  y86ex_pkg::stat_t      wb_stage_stat,
    // result channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  bubble,
    output y86ex_pkg::stat_t      status_out,
    output y86ex_pkg::code_t      icode_out,
    output logic                  cond,
    output y86ex_pkg::word_t      val_e,
    output y86ex_pkg::word_t      val_a_out,
    output y86ex_pkg::code_t      dest_e_out,
    output y86ex_pkg::code_t      dest_m_out
);

    localparam y86ex_pkg::word_t WORD_STEP = 32'(y86ex_pkg::WORD_BYTES);

    // Input register
    logic                 in_valid_reg;
    y86ex_pkg::stat_t     stat_reg;
    y86ex_pkg::code_t     icode_reg;
    y86ex_pkg::code_t     ifun_reg;
    y86ex_pkg::word_t     valc_reg;
    y86ex_pkg::word_t     vala_reg;
    y86ex_pkg::word_t     valb_reg;
    y86ex_pkg::code_t     deste_reg;
    y86ex_pkg::code_t     destm_reg;
    y86ex_pkg::stat_t     mstat_reg;
    y86ex_pkg::stat_t     wstat_reg;

    // Flag register
    y86ex_pkg::flags_t    flags_reg;
    y86ex_pkg::flags_t    flags_next;

    // Result register
    logic                 out_valid_reg;
    logic                 bubble_reg;
    y86ex_pkg::stat_t     status_out_reg;
    y86ex_pkg::code_t     icode_out_reg;
    logic                 cond_reg;
    y86ex_pkg::word_t     val_e_reg;
    y86ex_pkg::word_t     val_a_out_reg;
    y86ex_pkg::code_t     dest_e_out_reg;
    y86ex_pkg::code_t     dest_m_out_reg;

    // Combinational results
    logic                 adv_out;
    logic                 adv_in;
    logic                 bub;
    logic                 is_opl;
    logic                 alu_bad;
    logic                 alu_ov;
    y86ex_pkg::word_t     alu_res;
    y86ex_pkg::word_t     val_e_next;
    y86ex_pkg::stat_t     status_next;
    logic                 lt;
    logic                 cnd_eval;
    logic                 cond_next;
    y86ex_pkg::code_t     dest_e_next;

    // Pipeline advance: result register frees when empty or taken
    assign adv_out  = !out_valid_reg || !out_stall;
    assign adv_in   = !in_valid_reg || adv_out;
    assign in_stall = !adv_in;

    // Capture the input word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (adv_in)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_in && in_valid)
        begin
            stat_reg  <= status_in;
            icode_reg <= icode;
            ifun_reg  <= ifun;
            valc_reg  <= val_c;
            vala_reg  <= val_a;
            valb_reg  <= val_b;
            deste_reg <= dest_e;
            destm_reg <= dest_m;
            mstat_reg <= mem_stage_stat;
            wstat_reg <= wb_stage_stat;
        end
    end

    // Later-stage exception freezes flags and bubbles the M register
    assign bub    = (mstat_reg != y86ex_pkg::STAT_AOK) || (wstat_reg != y86ex_pkg::STAT_AOK);
    assign is_opl = (icode_reg == y86ex_pkg::I_OPL);

    // ALU for OPL
    always_comb
    begin
        alu_res = '0;
        alu_ov  = 1'b0;
        alu_bad = 1'b0;
        unique case (ifun_reg)
            y86ex_pkg::ALU_ADD:
            begin
                alu_res = valb_reg + vala_reg;
                alu_ov  = (vala_reg[31] == valb_reg[31]) && (alu_res[31] != vala_reg[31]);
            end
            y86ex_pkg::ALU_SUB:
            begin
                alu_res = valb_reg - vala_reg;
                alu_ov  = (vala_reg[31] != valb_reg[31]) && (alu_res[31] != valb_reg[31]);
            end
            y86ex_pkg::ALU_AND: alu_res = valb_reg & vala_reg;
            y86ex_pkg::ALU_XOR: alu_res = valb_reg ^ vala_reg;
            default:            alu_bad = 1'b1;
        endcase
    end

    // Select valE and status by instruction
    always_comb
    begin
        val_e_next  = '0;
        status_next = stat_reg;
        unique case (icode_reg) inside
            y86ex_pkg::I_RRMOVL:                     val_e_next = vala_reg;
            y86ex_pkg::I_IRMOVL, y86ex_pkg::I_DUMP:  val_e_next = valc_reg;
            y86ex_pkg::I_RMMOVL, y86ex_pkg::I_MRMOVL: val_e_next = valb_reg + valc_reg;
            y86ex_pkg::I_CALL, y86ex_pkg::I_PUSHL:   val_e_next = valb_reg - WORD_STEP;
            y86ex_pkg::I_RET, y86ex_pkg::I_POPL:     val_e_next = valb_reg + WORD_STEP;
            y86ex_pkg::I_OPL:
            begin
                if (!bub)
                begin
                    val_e_next = alu_res;
                    if (alu_bad)
                    begin
                        status_next = y86ex_pkg::STAT_INS;
                    end
                end
            end
            default:                                 val_e_next = '0;
        endcase
    end

    // Update flags for an unfrozen OPL; an invalid function leaves them clear
    always_comb
    begin
        flags_next = flags_reg;
        if (is_opl && !bub)
        begin
            flags_next.zf = !alu_bad && (alu_res == '0);
            flags_next.sf = !alu_bad && alu_res[31];
            flags_next.of = !alu_bad && alu_ov;
        end
    end

    // Evaluate condition from the flags left by the previous word
    assign lt = flags_reg.sf ^ flags_reg.of;

    always_comb
    begin
        unique case (ifun_reg)
            y86ex_pkg::C_ALWAYS: cnd_eval = 1'b1;
            y86ex_pkg::C_LE:     cnd_eval = lt || flags_reg.zf;
            y86ex_pkg::C_L:      cnd_eval = lt;
            y86ex_pkg::C_E:      cnd_eval = flags_reg.zf;
            y86ex_pkg::C_NE:     cnd_eval = !flags_reg.zf;
            y86ex_pkg::C_GE:     cnd_eval = !lt;
            y86ex_pkg::C_G:      cnd_eval = !lt && !flags_reg.zf;
            default:             cnd_eval = 1'b0;
        endcase
    end

    assign cond_next   = ((icode_reg == y86ex_pkg::I_RRMOVL) || (icode_reg == y86ex_pkg::I_JXX))
                         && cnd_eval;
    assign dest_e_next = ((icode_reg == y86ex_pkg::I_RRMOVL) && !cond_next) ?
                         y86ex_pkg::REG_NONE : deste_reg;

    // Advance flags and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv_out)
        begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                flags_reg <= flags_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_out && in_valid_reg)
        begin
            bubble_reg     <= bub;
            status_out_reg <= status_next;
            icode_out_reg  <= icode_reg;
            cond_reg       <= cond_next;
            val_e_reg      <= val_e_next;
            val_a_out_reg  <= vala_reg;
            dest_e_out_reg <= dest_e_next;
            dest_m_out_reg <= destm_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign bubble     = bubble_reg;
    assign status_out = status_out_reg;
    assign icode_out  = icode_out_reg;
    assign cond       = cond_reg;
    assign val_e      = val_e_reg;
    assign val_a_out  = val_a_out_reg;
    assign dest_e_out = dest_e_out_reg;
    assign dest_m_out = dest_m_out_reg;

    // Flags change only when an unfrozen OPL moves to the result register
    `ASSERT_NEXT(a_flags_hold, !(in_valid_reg && adv_out && is_opl && !bub), $stable(flags_reg))
    // A failed conditional move carries no destination
    `ASSERT_SAME(a_cmov_cancel, out_valid && icode_out == y86ex_pkg::I_RRMOVL && !cond,
                 dest_e_out == y86ex_pkg::REG_NONE)
    // Only moves and jumps report a condition
    `ASSERT_SAME(a_cond_src, out_valid && cond,
                 icode_out == y86ex_pkg::I_RRMOVL || icode_out == y86ex_pkg::I_JXX)
    // Input stalls only when both registers hold a word
    `ASSERT_SAME(a_stall_full, in_stall, in_valid_reg && out_valid_reg)

endmodule

// File: verif/y86_execute_stage_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// y86_execute_stage_test
// Self-checking bench for the Y86 execute stage. Instruction words are driven
// through the valid/stall input channel while a scoreboard predicts valE, the
// condition, the bubble and the ZF/SF/OF flag history. Each result word is
// compared field by field, in order, under random idling and back-pressure.
// ----------------------------------------------------------------------------

import y86ex_pkg::*;

// One result word as it leaves the stage
typedef struct packed {
    logic  bubble;
    stat_t status;
    code_t icode;
    logic  cond;
    word_t val_e;
    word_t val_a;
    code_t dest_e;
    code_t dest_m;
} exec_result_t;

// Predicts each result from the accepted instruction and the tracked flags
class exec_scoreboard;
    exec_result_t expected_q[$];
    flags_t       flags;
    int unsigned  accepted;
    int unsigned  checked;
    int unsigned  mismatches;
    int unsigned  bubbles;
    int unsigned  taken;

    function new();
        flags      = '0;
        accepted   = 0;
        checked    = 0;
        mismatches = 0;
        bubbles    = 0;
        taken      = 0;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    // Evaluate a branch or move condition against the current flags
    function logic cond_holds(code_t fn);
        logic lt;
        lt = flags.sf ^ flags.of;
        case (fn)
            C_ALWAYS: return 1'b1;
            C_LE:     return lt | flags.zf;
            C_L:      return lt;
            C_E:      return flags.zf;
            C_NE:     return ~flags.zf;
            C_GE:     return ~lt;
            C_G:      return ~lt & ~flags.zf;
            default:  return 1'b0;
        endcase
    endfunction

    // Note an accepted instruction word and queue its expected result
    function void note_input(stat_t st, code_t ic, code_t fn, word_t vc, word_t va,
                             word_t vb, code_t de, code_t dm, stat_t ms, stat_t ws);
        exec_result_t r;
        word_t        res;
        r          = '0;
        r.bubble   = (ms != STAT_AOK) || (ws != STAT_AOK);
        r.status   = st;
        r.icode    = ic;
        r.val_a    = va;
        r.dest_e   = de;
        r.dest_m   = dm;
        case (ic)
            I_RRMOVL:          r.val_e = va;
            I_IRMOVL, I_DUMP:  r.val_e = vc;
            I_RMMOVL, I_MRMOVL: r.val_e = vb + vc;
            I_CALL, I_PUSHL:   r.val_e = vb - word_t'(WORD_BYTES);
            I_RET, I_POPL:     r.val_e = vb + word_t'(WORD_BYTES);
            I_OPL:
            begin
                // Later-stage exception: freeze flags, leave valE at zero
                if (!r.bubble)
                begin
                    flags = '0;
                    res   = '0;
                    case (fn)
                        ALU_ADD:
                        begin
                            res      = vb + va;
                            flags.of = ~(va[31] ^ vb[31]) & (va[31] ^ res[31]);
                        end
                        ALU_SUB:
                        begin
                            res      = vb - va;
                            flags.of = (va[31] ^ vb[31]) & (vb[31] ^ res[31]);
                        end
                        ALU_AND: res = vb & va;
                        ALU_XOR: res = vb ^ va;
                        default: r.status = STAT_INS;
                    endcase
                    if (r.status != STAT_INS || st == STAT_INS)
                    begin
                        if (fn == ALU_ADD || fn == ALU_SUB || fn == ALU_AND
                            || fn == ALU_XOR)
                        begin
                            flags.zf = (res == '0);
                            flags.sf = res[31];
                        end
                    end
                    r.val_e = res;
                end
            end
            default: r.val_e = '0;
        endcase
        if (ic == I_RRMOVL || ic == I_JXX)
            r.cond = cond_holds(fn);
        // Cancel the destination of a move whose condition fails
        if (ic == I_RRMOVL && !r.cond)
            r.dest_e = REG_NONE;
        if (r.bubble)
            bubbles++;
        if (r.cond)
            taken++;
        accepted++;
        expected_q.push_back(r);
    endfunction

    function void report_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s in result %0d: expected %h, got %h",
                         name, checked, want, got);
        end
    endfunction

    // Compare one result word against the oldest expectation
    function void check_result(exec_result_t got);
        exec_result_t want;
        if (expected_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("result word with nothing expected: %h", got);
            return;
        end
        want = expected_q.pop_front();
        report_field("bubble", 32'(want.bubble), 32'(got.bubble));
        report_field("status_out", 32'(want.status), 32'(got.status));
        report_field("icode_out", 32'(want.icode), 32'(got.icode));
        report_field("cond", 32'(want.cond), 32'(got.cond));
        report_field("val_e", want.val_e, got.val_e);
        report_field("val_a_out", want.val_a, got.val_a);
        report_field("dest_e_out", 32'(want.dest_e), 32'(got.dest_e));
        report_field("dest_m_out", 32'(want.dest_m), 32'(got.dest_m));
        checked++;
    endfunction
endclass

module y86_execute_stage_test;

    localparam int HOLD_CYCLES = 80;
    localparam int PHASE_WORDS = 570;
    localparam longint TIMEOUT_NS = 2_000_000;

    logic  clk;
    logic  rst_n;
    logic  in_valid;
    logic  in_stall;
    stat_t status_in;
    code_t icode;
    code_t ifun;
    word_t val_c;
    word_t val_a;
    word_t val_b;
    code_t dest_e;
    code_t dest_m;
    stat_t mem_stage_stat;
    stat_t wb_stage_stat;
    logic  out_valid;
    logic  out_stall;
    logic  bubble;
    stat_t status_out;
    code_t icode_out;
    logic  cond;
    word_t val_e;
    word_t val_a_out;
    code_t dest_e_out;
    code_t dest_m_out;

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned hold_seq;

    exec_scoreboard board = new();

    y86_execute_stage dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .status_in      (status_in),
        .icode          (icode),
        .ifun           (ifun),
        .val_c          (val_c),
        .val_a          (val_a),
        .val_b          (val_b),
        .dest_e         (dest_e),
        .dest_m         (dest_m),
        .mem_stage_stat (mem_stage_stat),
        .wb_stage_stat  (wb_stage_stat),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .bubble         (bubble),
        .status_out     (status_out),
        .icode_out      (icode_out),
        .cond           (cond),
        .val_e          (val_e),
        .val_a_out      (val_a_out),
        .dest_e_out     (dest_e_out),
        .dest_m_out     (dest_m_out)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop if the run hangs
    initial
    begin
        #(TIMEOUT_NS);
        $display("CHECK FAILED");
        $finish;
    end

    // Watch both channels at the clock edge
    always @(posedge clk)
    begin
        exec_result_t got;
        got = '{bubble, status_out, icode_out, cond, val_e, val_a_out,
                dest_e_out, dest_m_out};
        if (rst_n && in_valid && !in_stall)
            board.note_input(status_in, icode, ifun, val_c, val_a, val_b, dest_e,
                             dest_m, mem_stage_stat, wb_stage_stat);
        if (rst_n && out_valid && !out_stall)
            board.check_result(got);
    end

    // Result side: random stalls, plus long hold-offs on request
    initial
    begin
        int unsigned hold_left;
        int unsigned hold_seen;
        hold_left = 0;
        hold_seen = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_seq != hold_seen)
            begin
                hold_seen = hold_seq;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Present one word and hold it until accepted
    task automatic drive_word(stat_t st, code_t ic, code_t fn, word_t vc, word_t va,
                              word_t vb, code_t de, code_t dm, stat_t ms, stat_t ws);
        in_valid       <= 1'b1;
        status_in      <= st;
        icode          <= ic;
        ifun           <= fn;
        val_c          <= vc;
        val_a          <= va;
        val_b          <= vb;
        dest_e         <= de;
        dest_m         <= dm;
        mem_stage_stat <= ms;
        wb_stage_stat  <= ws;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Drop valid for a random number of cycles
    task automatic maybe_idle();
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Stop sending and wait for every expected result
    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    // Operand values biased toward the sign and carry edges
    function automatic word_t pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hffff_ffff;
            2:       return 32'h7fff_ffff;
            3:       return 32'h8000_0000;
            4:       return word_t'($urandom_range(0, 16));
            5:       return -word_t'($urandom_range(1, 16));
            default: return $urandom;
        endcase
    endfunction

    function automatic stat_t pick_stat(int unsigned ok_pct);
        if ($urandom_range(0, 99) < ok_pct)
            return STAT_AOK;
        return stat_t'($urandom_range(1, 3));
    endfunction

    // Short directed sequence: flag producers followed by their consumers
    task automatic run_directed();
        drive_word(STAT_AOK, I_OPL, ALU_ADD, '0, 32'h1, 32'h7fff_ffff, 4'd0, REG_NONE,
                   STAT_AOK, STAT_AOK);
        drive_word(STAT_AOK, I_JXX, C_LE, 32'h100, '0, '0, REG_NONE, REG_NONE,
                   STAT_AOK, STAT_AOK);
        drive_word(STAT_AOK, I_RRMOVL, C_G, '0, 32'hdead_beef, '0, 4'd3, REG_NONE,
                   STAT_AOK, STAT_AOK);
        drive_word(STAT_AOK, I_OPL, ALU_SUB, '0, 32'h1, 32'h8000_0000, 4'd1, REG_NONE,
                   STAT_AOK, STAT_AOK);
        drive_word(STAT_AOK, I_JXX, C_L, 32'h200, '0, '0, REG_NONE, REG_NONE,
                   STAT_AOK, STAT_AOK);
        drive_word(STAT_AOK, I_RRMOVL, C_GE, '0, 32'h1234_5678, '0, 4'd5, REG_NONE,
                   STAT_AOK, STAT_AOK);
        drive_word(STAT_AOK, I_OPL, ALU_AND, '0, '0, 32'hffff_ffff, 4'd2, REG_NONE,
                   STAT_AOK, STAT_AOK);
        drive_word(STAT_AOK, I_JXX, C_E, 32'hffff_ffff, '0, '0, REG_NONE, REG_NONE,
                   STAT_AOK, STAT_AOK);
        drive_word(STAT_AOK, I_RRMOVL, C_NE, '0, 32'hffff_ffff, '0, 4'd6, REG_NONE,
                   STAT_AOK, STAT_AOK);
        drive_word(STAT_AOK, I_OPL, ALU_XOR, '0, '0, 32'hffff_ffff, 4'd7, REG_NONE,
                   STAT_AOK, STAT_AOK);
        // Bad ALU function, then unknown conditions
        drive_word(STAT_AOK, I_OPL, 4'd4, '0, 32'h5, 32'h5, 4'd0, REG_NONE,
                   STAT_AOK, STAT_AOK);
        drive_word(STAT_AOK, I_RRMOVL, 4'd7, '0, 32'h55aa_55aa, '0, 4'd4, 4'd2,
                   STAT_AOK, STAT_AOK);
        drive_word(STAT_AOK, I_JXX, 4'd15, 32'h8000_0000, '0, '0, REG_NONE, REG_NONE,
                   STAT_AOK, STAT_AOK);
        // Later-stage exceptions freeze flags and zero the ALU result
        drive_word(STAT_AOK, I_OPL, ALU_ADD, '0, 32'h7fff_ffff, 32'h1, 4'd1, REG_NONE,
                   STAT_ADR, STAT_AOK);
        drive_word(STAT_AOK, I_OPL, 4'd15, '0, 32'h3, 32'h9, 4'd1, REG_NONE,
                   STAT_AOK, STAT_HLT);
        // Every remaining instruction code, statuses cycling
        for (int i = 0; i < 16; i++)
        begin
            if (code_t'(i) != I_RRMOVL && code_t'(i) != I_OPL && code_t'(i) != I_JXX)
                drive_word(stat_t'(i % 4), code_t'(i), ALU_SUB, 32'hffff_ffff,
                           32'h8000_0000, (i % 2) ? 32'h0 : 32'hffff_ffff,
                           code_t'(i), code_t'(15 - i), STAT_AOK,
                           (i == 13) ? STAT_INS : STAT_AOK);
        end
    endtask

    // Random words, weighted toward ALU ops feeding branches and moves
    task automatic run_random(int unsigned count, bit with_hold);
        int unsigned pick;
        code_t       ic;
        code_t       fn;
        for (int unsigned n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
                ic = I_OPL;
            else if (pick < 45)
                ic = I_JXX;
            else if (pick < 60)
                ic = I_RRMOVL;
            else if (pick < 95)
                ic = code_t'($urandom_range(0, 12));
            else
                ic = code_t'($urandom_range(13, 15));
            if (ic == I_OPL)
                fn = ($urandom_range(0, 99) < 85) ? code_t'($urandom_range(0, 3))
                                                  : code_t'($urandom_range(4, 15));
            else if (ic == I_JXX || ic == I_RRMOVL)
                fn = ($urandom_range(0, 99) < 85) ? code_t'($urandom_range(0, 6))
                                                  : code_t'($urandom_range(7, 15));
            else
                fn = code_t'($urandom_range(0, 15));
            if (with_hold && n == 200)
                hold_seq++;
            drive_word(pick_stat(85), ic, fn, pick_word(), pick_word(), pick_word(),
                       code_t'($urandom_range(0, 15)), code_t'($urandom_range(0, 15)),
                       pick_stat(90), pick_stat(90));
            maybe_idle();
        end
    endtask

    // Sequence the run
    initial
    begin
        send_idle_pct   = 0;
        recv_idle_pct   = 0;
        hold_seq        = 0;
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        status_in      <= STAT_AOK;
        icode          <= I_NOP;
        ifun           <= '0;
        val_c          <= '0;
        val_a          <= '0;
        val_b          <= '0;
        dest_e         <= REG_NONE;
        dest_m         <= REG_NONE;
        mem_stage_stat <= STAT_AOK;
        wb_stage_stat  <= STAT_AOK;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        drain();

        // Sender mostly busy, receiver mostly stalled
        send_idle_pct = 7;
        recv_idle_pct = 68;
        run_random(PHASE_WORDS, 1'b0);
        drain();

        // Sender mostly idle, receiver mostly ready
        send_idle_pct = 68;
        recv_idle_pct = 7;
        run_random(PHASE_WORDS, 1'b0);
        drain();

        // Full rate, with one long hold-off on the result side
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(PHASE_WORDS, 1'b1);
        drain();
        repeat (20) @(posedge clk);

        $display("Drove %0d instruction words (%0d bubbled, %0d taken conditions), %0d checked",
                 board.accepted, board.bubbles, board.taken, board.checked);
        $display("Phases: directed, receiver-stalled, sender-idle, full rate with hold-off");
        if (board.mismatches == 0 && board.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
